### design/mlpq_pkg.sv
package mlpq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 128;
    localparam int DEFAULT_ID_WIDTH    = 14;

    localparam int CLASS_COUNT = 4;
    localparam int CLASS_W     = 2;

    typedef logic [CLASS_W-1:0] class_t;
    typedef logic [1:0]         status_t;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    localparam status_t ST_PUSHED = 2'd0;
    localparam status_t ST_POPPED = 2'd1;
    localparam status_t ST_FULL   = 2'd2;
    localparam status_t ST_EMPTY  = 2'd3;

endpackage

### design/mlpq_ram.sv
module mlpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/multilevel_priority_queue_top.sv
// Four-class strict-priority multilevel queue.
// Command channel: a beat is taken at a rising edge with start high and busy
// low. mode 0 pushes in_value into the FIFO of class in_value[1:0]; mode 1
// pops the oldest identifier of the highest non-empty class (class 3 first).
// Result channel: done strobes for exactly one cycle, in the cycle after the
// command beat, with out_value, out_class and status valid in that cycle.
// status: 0 pushed, 1 popped, 2 push refused (class FIFO full), 3 pop with
// every FIFO empty. out_value is zero on any result but a successful pop.
// A new command is taken every cycle; busy stays low.
// All four FIFOs share one RAM of 4*QUEUE_DEPTH entries with a registered
// read port: the pop read is issued at the command edge and its data shows
// up in the done cycle. A push writes at its command edge, so a pop in the
// very next cycle already sees it.
// Head, tail and fill counts live in flops; reset empties every FIFO at once
// and no RAM clearing is needed. The receiver cannot stall, so a result is
// never held; it must be captured in its done cycle.
module multilevel_priority_queue_top #(
    parameter int QUEUE_DEPTH = mlpq_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int ID_WIDTH    = mlpq_pkg::DEFAULT_ID_WIDTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    mode,
    input  logic [ID_WIDTH-1:0]     in_value,
    output logic                    done,
    output logic [ID_WIDTH-1:0]     out_value,
    output logic [1:0]              out_class,
    output logic [1:0]              status
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W = $clog2(mlpq_pkg::CLASS_COUNT * QUEUE_DEPTH);

    logic [mlpq_pkg::CLASS_COUNT-1:0][PTR_W-1:0] head_reg, head_next;
    logic [mlpq_pkg::CLASS_COUNT-1:0][PTR_W-1:0] tail_reg, tail_next;
    logic [mlpq_pkg::CLASS_COUNT-1:0][CNT_W-1:0] cnt_reg, cnt_next;

    logic                done_reg, done_next;
    mlpq_pkg::class_t    class_reg, class_next;
    mlpq_pkg::status_t   status_reg, status_next;

    logic                accept;
    mlpq_pkg::class_t    push_cls;
    mlpq_pkg::class_t    pop_cls;
    logic                pop_hit;
    logic                wr_en;
    logic                rd_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ID_WIDTH-1:0] rd_data;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign push_cls = in_value[mlpq_pkg::CLASS_W-1:0];

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    // highest non-empty class wins
    always_comb
    begin
        pop_hit = 1'b0;
        pop_cls = '0;
        for (int i = 0; i < mlpq_pkg::CLASS_COUNT; i++)
        begin
            if (cnt_reg[i] != '0)
            begin
                pop_hit = 1'b1;
                pop_cls = mlpq_pkg::CLASS_W'(i);
            end
        end
    end

    assign wr_addr = ADDR_W'(push_cls) * ADDR_W'(QUEUE_DEPTH)
                   + ADDR_W'(tail_reg[push_cls]);
    assign rd_addr = ADDR_W'(pop_cls) * ADDR_W'(QUEUE_DEPTH)
                   + ADDR_W'(head_reg[pop_cls]);

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        cnt_next    = cnt_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        done_next   = accept;
        class_next  = class_reg;
        status_next = status_reg;
        if (accept)
        begin
            if (mode == mlpq_pkg::MODE_PUSH)
            begin
                class_next = push_cls;
                if (cnt_reg[push_cls] == CNT_W'(QUEUE_DEPTH))
                begin
                    status_next = mlpq_pkg::ST_FULL;
                end
                else
                begin
                    wr_en               = 1'b1;
                    tail_next[push_cls] = advance(tail_reg[push_cls]);
                    cnt_next[push_cls]  = cnt_reg[push_cls] + CNT_W'(1);
                    status_next         = mlpq_pkg::ST_PUSHED;
                end
            end
            else if (pop_hit)
            begin
                rd_en              = 1'b1;
                head_next[pop_cls] = advance(head_reg[pop_cls]);
                cnt_next[pop_cls]  = cnt_reg[pop_cls] - CNT_W'(1);
                class_next         = pop_cls;
                status_next        = mlpq_pkg::ST_POPPED;
            end
            else
            begin
                class_next  = '0;
                status_next = mlpq_pkg::ST_EMPTY;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
            class_reg  <= '0;
            status_reg <= mlpq_pkg::ST_PUSHED;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            cnt_reg    <= cnt_next;
            done_reg   <= done_next;
            class_reg  <= class_next;
            status_reg <= status_next;
        end
    end

    mlpq_ram #(
        .WIDTH (ID_WIDTH),
        .DEPTH (mlpq_pkg::CLASS_COUNT * QUEUE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (in_value),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign done      = done_reg;
    assign out_class = class_reg;
    assign status    = status_reg;
    assign out_value = (status_reg == mlpq_pkg::ST_POPPED) ? rd_data : '0;

endmodule

### verif/multilevel_priority_queue_top_tb.sv
module multilevel_priority_queue_top_tb;

    localparam int ID_W      = mlpq_pkg::DEFAULT_ID_WIDTH;
    localparam int DEPTH     = mlpq_pkg::DEFAULT_QUEUE_DEPTH;
    localparam int WDOG_MAX  = 2000;
    localparam int TAIL_WAIT = 4;

    typedef struct packed {
        logic [ID_W-1:0]   value;
        mlpq_pkg::class_t  cls;
        mlpq_pkg::status_t st;
    } sched_result_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            start = 1'b0;
    logic            mode = mlpq_pkg::MODE_PUSH;
    logic [ID_W-1:0] in_value = '0;
    logic            busy;
    logic            done;
    logic [ID_W-1:0] out_value;
    logic [1:0]      out_class;
    logic [1:0]      status;

    // shadow copy of the four class FIFOs
    logic [ID_W-1:0] shadow_mem [0:mlpq_pkg::CLASS_COUNT*DEPTH-1];
    int              shadow_head [0:mlpq_pkg::CLASS_COUNT-1];
    int              shadow_tail [0:mlpq_pkg::CLASS_COUNT-1];
    int              shadow_fill [0:mlpq_pkg::CLASS_COUNT-1];

    sched_result_t   pending_results[$];
    int              error_count = 0;
    int              stall_cycles = 0;
    bit              idle_enable = 1'b1;

    multilevel_priority_queue_top #(
        .QUEUE_DEPTH(DEPTH),
        .ID_WIDTH   (ID_W)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .mode     (mode),
        .in_value (in_value),
        .done     (done),
        .out_value(out_value),
        .out_class(out_class),
        .status   (status)
    );

    always #6 clk = ~clk;

    function automatic sched_result_t schedule_op(input logic m, input logic [ID_W-1:0] v);
        sched_result_t r;
        int            c;
        int            found;
        r.value = '0;
        r.cls   = '0;
        r.st    = mlpq_pkg::ST_EMPTY;
        if (m == mlpq_pkg::MODE_PUSH)
        begin
            c     = int'(v[mlpq_pkg::CLASS_W-1:0]);
            r.cls = mlpq_pkg::class_t'(c);
            if (shadow_fill[c] >= DEPTH)
            begin
                r.st = mlpq_pkg::ST_FULL;
            end
            else
            begin
                shadow_mem[c*DEPTH + shadow_tail[c]] = v;
                shadow_tail[c] = (shadow_tail[c] + 1) % DEPTH;
                shadow_fill[c] = shadow_fill[c] + 1;
                r.st = mlpq_pkg::ST_PUSHED;
            end
        end
        else
        begin
            found = 0;
            for (c = mlpq_pkg::CLASS_COUNT-1; c >= 0; c--)
            begin
                if (found == 0 && shadow_fill[c] != 0)
                begin
                    r.value = shadow_mem[c*DEPTH + shadow_head[c]];
                    shadow_head[c] = (shadow_head[c] + 1) % DEPTH;
                    shadow_fill[c] = shadow_fill[c] - 1;
                    r.cls = mlpq_pkg::class_t'(c);
                    r.st  = mlpq_pkg::ST_POPPED;
                    found = 1;
                end
            end
        end
        return r;
    endfunction

    // result check, prediction at acceptance, watchdog
    always @(posedge clk)
    begin
        sched_result_t exp_r;
        bit            activity;
        if (rst_n)
        begin
            activity = 1'b0;
            if (done)
            begin
                activity = 1'b1;
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result beat: value %0d class %0d status %0d",
                           out_value, out_class, status);
                    error_count++;
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (out_value !== exp_r.value)
                    begin
                        $error("out_value: expected %0d, actual %0d", exp_r.value, out_value);
                        error_count++;
                    end
                    if (out_class !== exp_r.cls)
                    begin
                        $error("out_class: expected %0d, actual %0d", exp_r.cls, out_class);
                        error_count++;
                    end
                    if (status !== exp_r.st)
                    begin
                        $error("status: expected %0d, actual %0d", exp_r.st, status);
                        error_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                activity = 1'b1;
                pending_results.push_back(schedule_op(mode, in_value));
            end
            stall_cycles = activity ? 0 : stall_cycles + 1;
            if (stall_cycles >= WDOG_MAX)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send_cmd(input logic m, input logic [ID_W-1:0] v);
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        start    <= 1'b1;
        mode     <= m;
        in_value <= v;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic push_id(input logic [ID_W-1:0] v);
        send_cmd(mlpq_pkg::MODE_PUSH, v);
    endtask

    task automatic pop_id();
        send_cmd(mlpq_pkg::MODE_POP, ID_W'($urandom));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic test_priority_order();
        pop_id();                        // every FIFO empty
        push_id('0);
        push_id({ID_W{1'b1}});
        push_id(ID_W'(1));
        push_id(ID_W'(2));
        push_id({{(ID_W-2){1'b1}}, 2'd1});
        push_id({{(ID_W-2){1'b1}}, 2'd0});
        push_id(ID_W'(7));
        push_id(ID_W'(6));
        repeat (8) pop_id();             // 3,3,2,2,1,1,0,0
        pop_id();
        push_id(ID_W'(4));               // push then pop, idle cycles may fall between
        pop_id();
        push_id(ID_W'(9));
        push_id(ID_W'(11));
        pop_id();
        pop_id();
        pop_id();
    endtask

    task automatic test_full_fifo();
        int i;
        for (i = 0; i < DEPTH; i++)
            push_id({(ID_W-2)'($urandom_range(0, (1 << (ID_W-2)) - 1)), 2'd2});
        push_id({(ID_W-2)'($urandom_range(0, (1 << (ID_W-2)) - 1)), 2'd2});
        push_id({{(ID_W-2){1'b1}}, 2'd2});
        push_id(ID_W'(3));               // other class still accepts
        for (i = 0; i < DEPTH + 2; i++)
            pop_id();
    endtask

    // phases alternate push-heavy, pop-heavy and balanced traffic
    task automatic test_random_traffic(input int n_items);
        int   i;
        int   phase;
        int   push_pct;
        int   fav_class;
        logic [ID_W-1:0] v;
        phase = 0;
        push_pct = 50;
        fav_class = 0;
        for (i = 0; i < n_items; i++)
        begin
            if (i % 200 == 0)
            begin
                if (phase % 2 == 1)
                    wait_drained();
                case (phase % 3)
                    0: push_pct = 90;
                    1: push_pct = 15;
                    default: push_pct = 50;
                endcase
                fav_class   = $urandom_range(0, mlpq_pkg::CLASS_COUNT-1);
                idle_enable = ($urandom_range(0, 2) != 0);
                phase++;
            end
            v = ID_W'($urandom);
            if ($urandom_range(0, 99) < 60)
                v[mlpq_pkg::CLASS_W-1:0] = mlpq_pkg::class_t'(fav_class);
            if ($urandom_range(0, 99) < push_pct)
                push_id(v);
            else
                pop_id();
        end
    endtask

    task automatic test_back_to_back(input int n_items);
        int i;
        idle_enable = 1'b0;
        for (i = 0; i < n_items; i++)
        begin
            if ($urandom_range(0, 1) == 0)
                push_id(ID_W'($urandom));
            else
                pop_id();
        end
    endtask

    initial
    begin
        int c;
        for (c = 0; c < mlpq_pkg::CLASS_COUNT; c++)
        begin
            shadow_head[c] = 0;
            shadow_tail[c] = 0;
            shadow_fill[c] = 0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_priority_order();
        test_full_fifo();
        test_random_traffic(1000);
        test_back_to_back(300);

        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
design/mlpq_pkg.sv
design/mlpq_ram.sv
design/multilevel_priority_queue_top.sv
verif/multilevel_priority_queue_top_tb.sv
